### rtl/cosine_similarity_engine_core_defines.svh
// Assertion macros for the cosine similarity engine.
`ifndef COSINE_SIMILARITY_ENGINE_CORE_DEFINES_SVH
`define COSINE_SIMILARITY_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cse_pkg.sv
// Shared types and constants of the cosine similarity engine.
package cse_pkg;

  localparam int ELEMENT_BITS = 16;
  localparam int SQ_BITS      = 40;
  localparam int DOT_BITS     = 41;
  localparam int ROOT_BITS    = SQ_BITS / 2;
  localparam int ROOT_STEPS   = SQ_BITS / 2;
  localparam int FRAC_BITS    = 14;
  localparam int Q_BITS       = FRAC_BITS + 1;
  localparam int CNT_BITS     = $clog2(ROOT_STEPS);
  localparam int RESULT_BITS  = 16;

  localparam logic [Q_BITS-1:0] ONE_Q14 = Q_BITS'(1 << FRAC_BITS);

  typedef logic signed [ELEMENT_BITS-1:0] element_t;

  typedef struct packed {
    logic acc_en;
    logic root_init;
    logic root_step;
    logic den_load;
    logic div_init;
    logic div_step;
    logic finish;
  } cse_cmd_t;

endpackage

### rtl/cse_ctrl.sv
// Sequencer of the cosine similarity engine: accept, root, multiply, divide, emit.
module cse_ctrl import cse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     last_element,
  output logic     busy,
  output logic     done,
  output cse_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROOT,
    S_MUL,
    S_DIVLD,
    S_DIV,
    S_FINISH
  } state_t;

  state_t              state;
  logic [CNT_BITS-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
      unique case (state)
        S_IDLE: begin
          if (start && last_element) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt   <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (cnt == CNT_BITS'(ROOT_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_MUL;
          end else begin
            cnt <= cnt + CNT_BITS'(1);
          end
        end
        S_MUL: begin
          state <= S_DIVLD;
        end
        S_DIVLD: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == CNT_BITS'(Q_BITS - 1)) begin
            cnt   <= '0;
            state <= S_FINISH;
          end else begin
            cnt <= cnt + CNT_BITS'(1);
          end
        end
        S_FINISH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    busy          = (state != S_IDLE);
    cmd.acc_en    = (state == S_IDLE) && start;
    cmd.root_init = (state == S_LOAD);
    cmd.root_step = (state == S_ROOT);
    cmd.den_load  = (state == S_MUL);
    cmd.div_init  = (state == S_DIVLD);
    cmd.div_step  = (state == S_DIV);
    cmd.finish    = (state == S_FINISH);
  end

endmodule

### rtl/cse_dp.sv
// Datapath: accumulators, two square-root units, norm product and restoring divider.
module cse_dp import cse_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  cse_cmd_t                       cmd,
  input  element_t                       x_value,
  input  element_t                       y_value,
  output logic signed [RESULT_BITS-1:0]  cosine_q14,
  output logic                           zero_norm
);

  localparam int PROD_BITS = 2 * ELEMENT_BITS;
  localparam int REM_BITS  = DOT_BITS + FRAC_BITS;
  localparam int DSH_BITS  = SQ_BITS + FRAC_BITS;
  localparam logic signed [DOT_BITS-1:0] DOT_MAX = {1'b0, {(DOT_BITS-1){1'b1}}};
  localparam logic signed [DOT_BITS-1:0] DOT_MIN = {1'b1, {(DOT_BITS-1){1'b0}}};
  localparam logic [SQ_BITS-1:0] ROOT_TOP = SQ_BITS'(1) << (SQ_BITS - 2);

  logic signed [DOT_BITS-1:0]  dot_sum;
  logic [SQ_BITS-1:0]          square_sum_x;
  logic [SQ_BITS-1:0]          square_sum_y;

  logic signed [PROD_BITS-1:0] p_xy;
  logic signed [PROD_BITS-1:0] p_xx;
  logic signed [PROD_BITS-1:0] p_yy;
  logic signed [DOT_BITS:0]    dot_add;
  logic [SQ_BITS:0]            sx_add;
  logic [SQ_BITS:0]            sy_add;
  logic signed [DOT_BITS-1:0]  dot_next;
  logic [SQ_BITS-1:0]          sx_next;
  logic [SQ_BITS-1:0]          sy_next;

  logic [SQ_BITS-1:0]          vx;
  logic [SQ_BITS-1:0]          vy;
  logic [SQ_BITS-1:0]          rtx;
  logic [SQ_BITS-1:0]          rty;
  logic [SQ_BITS-1:0]          rbit;
  logic [SQ_BITS:0]            trial_x;
  logic [SQ_BITS:0]            trial_y;
  logic                        zf;

  logic [SQ_BITS-1:0]          den;
  logic [DOT_BITS-1:0]         mag;
  logic [REM_BITS-1:0]         rem;
  logic [DSH_BITS-1:0]         dsh;
  logic [Q_BITS-1:0]           quo;
  logic                        big;
  logic [Q_BITS-1:0]           q_clamped;

  always_comb begin
    p_xy    = PROD_BITS'(x_value * y_value);
    p_xx    = PROD_BITS'(x_value * x_value);
    p_yy    = PROD_BITS'(y_value * y_value);
    dot_add = (DOT_BITS + 1)'(dot_sum) + (DOT_BITS + 1)'(p_xy);
    sx_add  = {1'b0, square_sum_x} + (SQ_BITS + 1)'(unsigned'(p_xx));
    sy_add  = {1'b0, square_sum_y} + (SQ_BITS + 1)'(unsigned'(p_yy));
    if (dot_add[DOT_BITS] != dot_add[DOT_BITS-1]) begin
      dot_next = dot_add[DOT_BITS] ? DOT_MIN : DOT_MAX;
    end else begin
      dot_next = dot_add[DOT_BITS-1:0];
    end
    sx_next = sx_add[SQ_BITS] ? {SQ_BITS{1'b1}} : sx_add[SQ_BITS-1:0];
    sy_next = sy_add[SQ_BITS] ? {SQ_BITS{1'b1}} : sy_add[SQ_BITS-1:0];
    trial_x = {1'b0, rtx} + {1'b0, rbit};
    trial_y = {1'b0, rty} + {1'b0, rbit};
    mag     = dot_sum[DOT_BITS-1] ? DOT_BITS'(-dot_sum) : DOT_BITS'(dot_sum);
    if (big || (quo > ONE_Q14)) begin
      q_clamped = ONE_Q14;
    end else begin
      q_clamped = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum      <= '0;
      square_sum_x <= '0;
      square_sum_y <= '0;
    end else if (cmd.acc_en) begin
      dot_sum      <= dot_next;
      square_sum_x <= sx_next;
      square_sum_y <= sy_next;
    end else if (cmd.finish) begin
      dot_sum      <= '0;
      square_sum_x <= '0;
      square_sum_y <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      vx   <= square_sum_x;
      vy   <= square_sum_y;
      rtx  <= '0;
      rty  <= '0;
      rbit <= ROOT_TOP;
      zf   <= (square_sum_x == '0) || (square_sum_y == '0);
    end else if (cmd.root_step) begin
      if ({1'b0, vx} >= trial_x) begin
        vx  <= vx - trial_x[SQ_BITS-1:0];
        rtx <= (rtx >> 1) + rbit;
      end else begin
        rtx <= rtx >> 1;
      end
      if ({1'b0, vy} >= trial_y) begin
        vy  <= vy - trial_y[SQ_BITS-1:0];
        rty <= (rty >> 1) + rbit;
      end else begin
        rty <= rty >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.den_load) begin
      den <= SQ_BITS'(rtx[ROOT_BITS-1:0] * rty[ROOT_BITS-1:0]);
    end
    if (cmd.div_init) begin
      rem <= {mag, {FRAC_BITS{1'b0}}};
      dsh <= {den, {FRAC_BITS{1'b0}}};
      quo <= '0;
      big <= (mag >= {den, 1'b0});
    end else if (cmd.div_step) begin
      if (rem >= {1'b0, dsh}) begin
        rem <= rem - {1'b0, dsh};
        quo <= {quo[Q_BITS-2:0], 1'b1};
      end else begin
        quo <= {quo[Q_BITS-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      zero_norm <= zf;
      if (zf) begin
        cosine_q14 <= '0;
      end else if (dot_sum[DOT_BITS-1]) begin
        cosine_q14 <= -RESULT_BITS'(q_clamped);
      end else begin
        cosine_q14 <= RESULT_BITS'(q_clamped);
      end
    end
  end

endmodule

### rtl/cosine_similarity_engine_core.sv
// Top level of the cosine similarity engine: sequencer plus datapath.
//
//   channel   ports                                   handshake
//   input     x_value, y_value, last_element          start high, busy low
//   result    cosine_q14, zero_norm                   done, one cycle
//
// An element pair is accepted every cycle while busy is low; accumulation
// takes effect at the accepting edge. A pair marked last holds busy high
// through a load, 20 square-root steps, a norm multiply, a divider load,
// 15 quotient bits and a finish; done rises in the cycle busy drops, and
// a new pair may be taken in that same cycle. Reset clears the sequencer
// and the accumulators. The receiver cannot stall the result.
`include "cosine_similarity_engine_core_defines.svh"

module cosine_similarity_engine_core import cse_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  element_t                      x_value,
  input  element_t                      y_value,
  input  logic                          last_element,
  output logic                          done,
  output logic signed [RESULT_BITS-1:0] cosine_q14,
  output logic                          zero_norm
);

  cse_cmd_t cmd;

  cse_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_element (last_element),
    .busy         (busy),
    .done         (done),
    .cmd          (cmd)
  );

  cse_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .x_value    (x_value),
    .y_value    (y_value),
    .cosine_q14 (cosine_q14),
    .zero_norm  (zero_norm)
  );

  `CSE_ASSERT_NEXT(a_last_goes_busy, start && !busy && last_element, busy && !done, "last word did not start the result sequence")
  `CSE_ASSERT_NOW(a_done_not_busy, done, !busy, "result shown while busy")
  `CSE_ASSERT_NOW(a_zero_norm_result, done && zero_norm, cosine_q14 == '0, "zero norm with nonzero result")
  `CSE_ASSERT_NOW(a_result_range, done, (cosine_q14 <= 16'sd16384) && (cosine_q14 >= -16'sd16384), "result outside unit range")

endmodule

### sim/testbench.sv
// Self-checking testbench for the cosine similarity engine core.
module testbench;
  import cse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint          DotMax = (longint'(1) << (DOT_BITS - 1)) - 1;
  localparam longint          DotMin = -DotMax - 1;
  localparam longint unsigned SqMax  = (longint'(1) << SQ_BITS) - 1;
  localparam longint unsigned OneQ14 = longint'(1) << FRAC_BITS;
  localparam int              RandomPairs = 700;

  typedef struct packed {
    logic signed [RESULT_BITS-1:0] cosine;
    logic                          zero_norm;
  } cosine_word_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  element_t                      x_value;
  element_t                      y_value;
  logic                          last_element;
  logic                          done;
  logic signed [RESULT_BITS-1:0] cosine_q14;
  logic                          zero_norm;

  longint          dot_acc;
  longint unsigned sq_x_acc;
  longint unsigned sq_y_acc;
  cosine_word_t    expected_cosine_q[$];
  cosine_word_t    oldest;
  int              failures;
  int              pairs_sent;
  int              vectors_sent;
  int              results_checked;
  int              zero_norm_seen;

  cosine_similarity_engine_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .x_value      (x_value),
    .y_value      (y_value),
    .last_element (last_element),
    .done         (done),
    .cosine_q14   (cosine_q14),
    .zero_norm    (zero_norm)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    int              b;
    root = 0;
    for (b = 20; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void track_pair(input element_t x, input element_t y, input logic last);
    longint          xl;
    longint          yl;
    longint          d;
    longint unsigned sx;
    longint unsigned sy;
    longint unsigned rx;
    longint unsigned ry;
    longint unsigned mag;
    longint unsigned q;
    cosine_word_t    w;
    xl = x;
    yl = y;
    d = dot_acc + xl * yl;
    if (d > DotMax) d = DotMax;
    if (d < DotMin) d = DotMin;
    dot_acc = d;
    sx = sq_x_acc + longint'(xl * xl);
    sy = sq_y_acc + longint'(yl * yl);
    sq_x_acc = (sx > SqMax) ? SqMax : sx;
    sq_y_acc = (sy > SqMax) ? SqMax : sy;
    if (!last) return;
    rx = floor_sqrt(sq_x_acc);
    ry = floor_sqrt(sq_y_acc);
    if (rx == 0 || ry == 0) begin
      w.cosine    = '0;
      w.zero_norm = 1'b1;
    end else begin
      mag = (dot_acc < 0) ? longint'(-dot_acc) : longint'(dot_acc);
      q = (mag * OneQ14) / (rx * ry);
      if (q > OneQ14) q = OneQ14;
      w.cosine    = (dot_acc < 0) ? -RESULT_BITS'(q) : RESULT_BITS'(q);
      w.zero_norm = 1'b0;
    end
    expected_cosine_q.push_back(w);
    dot_acc  = 0;
    sq_x_acc = 0;
    sq_y_acc = 0;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_cosine_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual cosine_q14=%0d zero_norm=%0b",
                 $time, cosine_q14, zero_norm);
        failures++;
      end else begin
        oldest = expected_cosine_q.pop_front();
        results_checked++;
        if (zero_norm) zero_norm_seen++;
        if (cosine_q14 !== oldest.cosine) begin
          $display("%0t: cosine_q14 mismatch: expected %0d, actual %0d",
                   $time, oldest.cosine, cosine_q14);
          failures++;
        end
        if (zero_norm !== oldest.zero_norm) begin
          $display("%0t: zero_norm mismatch: expected %0b, actual %0b",
                   $time, oldest.zero_norm, zero_norm);
          failures++;
        end
      end
    end
  end

  task automatic send_pair(input element_t x, input element_t y, input logic last,
                           input int max_gap);
    int gap;
    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    x_value      <= x;
    y_value      <= y;
    last_element <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_pair(x, y, last);
    pairs_sent++;
    if (last) vectors_sent++;
  endtask

  task automatic test_extremes();
    send_pair(16'sh7fff, 16'sh7fff, 1'b1, 15);
    send_pair(-16'sh8000, -16'sh8000, 1'b1, 15);
    send_pair(-16'sh8000, 16'sh7fff, 1'b1, 15);
    send_pair(16'sh7fff, -16'sh8000, 1'b1, 0);
    send_pair(16'sh4000, -16'sh4000, 1'b1, 0);
    send_pair(-16'sd1, 16'sd1, 1'b1, 15);
    send_pair(16'sh7fff, 16'sd1, 1'b0, 15);
    send_pair(16'sd1, 16'sh7fff, 1'b1, 15);
    send_pair(16'sh5555, -16'sh2aab, 1'b0, 0);
    send_pair(-16'sh5556, 16'sh2aaa, 1'b0, 0);
    send_pair(16'sh0100, 16'sh0003, 1'b1, 0);
  endtask

  task automatic test_zero_norm();
    send_pair(16'sd0, 16'sd5, 1'b1, 15);
    send_pair(-16'sd7, 16'sd0, 1'b1, 15);
    send_pair(16'sd0, 16'sd0, 1'b1, 0);
    send_pair(16'sd0, 16'sh7fff, 1'b0, 0);
    send_pair(16'sd0, -16'sh8000, 1'b1, 0);
  endtask

  task automatic test_ratio_clamp();
    send_pair(16'sd1, 16'sd1, 1'b0, 15);
    send_pair(16'sd1, 16'sd1, 1'b1, 15);
    send_pair(16'sd1, -16'sd1, 1'b0, 0);
    send_pair(16'sd1, -16'sd1, 1'b1, 0);
    send_pair(16'sd2, 16'sd2, 1'b0, 15);
    send_pair(16'sd2, 16'sd2, 1'b0, 15);
    send_pair(16'sd2, 16'sd2, 1'b1, 15);
  endtask

  function automatic element_t pick_element(input int style);
    case (style)
      0, 1: return element_t'($urandom);
      2: return element_t'(int'($urandom_range(0, 8)) - 4);
      3: begin
        case ($urandom_range(0, 6))
          0: return -16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh4000;
          3: return -16'sh4000;
          4: return 16'sd1;
          5: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return ($urandom_range(0, 3) == 0) ? element_t'($urandom) : 16'sd0;
    endcase
  endfunction

  task automatic test_random_vectors();
    int       len;
    int       i;
    int       x_style;
    int       y_style;
    int       relation;
    int       max_gap;
    element_t x;
    element_t y;
    while (pairs_sent < RandomPairs) begin
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      x_style  = $urandom_range(0, 4);
      y_style  = $urandom_range(0, 4);
      relation = $urandom_range(0, 6);
      max_gap  = ($urandom_range(0, 3) == 0) ? 0 : 15;
      for (i = 0; i < len; i++) begin
        x = (relation == 6) ? 16'sd0 : pick_element(x_style);
        case (relation)
          3: y = x;
          4: y = -x;
          5: y = x + element_t'(int'($urandom_range(0, 6)) - 3);
          default: y = pick_element(y_style);
        endcase
        send_pair(x, y, i == len - 1, max_gap);
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    x_value      <= '0;
    y_value      <= '0;
    last_element <= 1'b0;
    dot_acc      = 0;
    sq_x_acc     = 0;
    sq_y_acc     = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_zero_norm();
    test_ratio_clamp();
    test_random_vectors();

    start <= 1'b0;
    while (expected_cosine_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d element pairs in %0d vectors: extremes, zero norms, clamps, random.",
             pairs_sent, vectors_sent);
    $display("Checked %0d results, %0d of them zero norm.", results_checked, zero_norm_seen);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### cosine_similarity_engine_core.f
+incdir+rtl
rtl/cse_pkg.sv
rtl/cse_ctrl.sv
rtl/cse_dp.sv
rtl/cosine_similarity_engine_core.sv
sim/testbench.sv
